// ----- hw/rtl/prat_pkg.sv -----
// Package for the packet reorder / ack tracker.
// Holds window constants, action and kind codes, and the transfer structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prat_pkg;

  localparam int WINDOW_SLOTS = 32;
  localparam int MAX_PAYLOAD  = 1024;
  localparam int SLOT_W       = 5;
  localparam int SEQ_W        = 31;
  localparam int LEN_W        = 11;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;

  typedef enum logic [2:0] {
    ACT_DELIVER_IN   = 3'd0,
    ACT_STORE        = 3'd1,
    ACT_DELIVER_SLOT = 3'd2,
    ACT_ACK          = 3'd3,
    ACT_DONE_ACK     = 3'd4
  } action_t;

  typedef struct packed {
    logic [1:0]       packet_kind;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
  } prat_in_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]  byte_count;
    logic [SEQ_W-1:0]  ack_number;
    logic              last;
  } prat_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/packet_reorder_ack_tracker.sv -----
// Receive-side reorder window and ack generator, one header per transfer.
// Depends on prat_pkg; slot lengths sit in a local memory with a registered read.
//
//   Port group | Dir | Carries
//   in_*       | in  | packet header (kind, sequence number, length)
//   out_*      | out | action, slot, byte count, ack number, last flag
//
// A done or dropped header goes from DECIDE back to idle, an early one is
// stored and then acked in ACK, and an in-order one is delivered, then loops
// through CHECK and DRAIN once per held slot drained (DRAIN uses the registered
// length read) before ACK; an ignored kind stays in idle. Output stalls hold the state.
// Reset clears the expected number, ring head, held bitmap and finished flag.
// Inputs are taken only in the idle state; a done packet stops the block.
`timescale 1ns / 1ps
`default_nettype none

module packet_reorder_ack_tracker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  prat_pkg::prat_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output prat_pkg::prat_out_t out_data
);

  import prat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_DRAIN,
    S_ACK
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SEQ_W-1:0]        exp_r, exp_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [WINDOW_SLOTS-1:0] held_r, held_nxt;
  logic                    finished_r, finished_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [SEQ_W-1:0]        gap_r, gap_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [SLOT_W-1:0]       drained_r, drained_nxt;
  logic                    out_valid_r, out_valid_nxt;
  prat_out_t               out_data_r, out_data_nxt;

  logic [LEN_W-1:0]        slot_len_mem [WINDOW_SLOTS];
  logic [LEN_W-1:0]        rd_len_r;
  logic                    mem_we;
  logic [SLOT_W-1:0]       store_slot;
  logic [SLOT_W:0]         slot_sum;
  logic [SLOT_W-1:0]       head_inc;
  logic                    can_emit;
  logic                    emit;
  prat_out_t               emit_data;

  assign can_emit  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slot_sum   = {1'b0, head_r} + {1'b0, gap_r[SLOT_W-1:0]};
  assign store_slot = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS))
                      : slot_sum[SLOT_W-1:0];
  assign head_inc   = (head_r == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    exp_nxt      = exp_r;
    head_nxt     = head_r;
    held_nxt     = held_r;
    finished_nxt = finished_r;
    kind_nxt     = kind_r;
    gap_nxt      = gap_r;
    len_nxt      = len_r;
    drained_nxt  = drained_r;
    mem_we       = 1'b0;
    emit         = 1'b0;
    emit_data    = '{action: ACT_ACK, slot_index: '0, byte_count: '0,
                     ack_number: '0, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !finished_r) begin
          kind_nxt = in_data.packet_kind;
          gap_nxt  = in_data.seq_number - exp_r;
          len_nxt  = (in_data.payload_length > LEN_W'(MAX_PAYLOAD))
                     ? LEN_W'(MAX_PAYLOAD) : in_data.payload_length;
          if (in_data.packet_kind == KIND_DATA || in_data.packet_kind == KIND_DONE) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (can_emit) begin
          emit = 1'b1;
          priority if (kind_r == KIND_DONE) begin
            emit_data.action     = ACT_DONE_ACK;
            emit_data.ack_number = exp_r;
            emit_data.last       = 1'b1;
            finished_nxt         = 1'b1;
            state_nxt            = S_IDLE;
          end else if (gap_r == '0) begin
            emit_data.action     = ACT_DELIVER_IN;
            emit_data.byte_count = len_r;
            exp_nxt              = exp_r + 1'b1;
            head_nxt             = head_inc;
            drained_nxt          = '0;
            state_nxt            = S_CHECK;
          end else if (gap_r < SEQ_W'(WINDOW_SLOTS)) begin
            emit_data.action     = ACT_STORE;
            emit_data.slot_index = store_slot;
            emit_data.byte_count = len_r;
            held_nxt[store_slot] = 1'b1;
            mem_we               = 1'b1;
            state_nxt            = S_ACK;
          end else begin
            emit_data.ack_number = exp_r;
            emit_data.last       = 1'b1;
            state_nxt            = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (held_r[head_r] && drained_r != SLOT_W'(WINDOW_SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_DRAIN: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_data.action     = ACT_DELIVER_SLOT;
          emit_data.slot_index = head_r;
          emit_data.byte_count = rd_len_r;
          held_nxt[head_r]     = 1'b0;
          head_nxt             = head_inc;
          exp_nxt              = exp_r + 1'b1;
          drained_nxt          = drained_r + 1'b1;
          state_nxt            = S_CHECK;
        end
      end
      S_ACK: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_data.ack_number = exp_r;
          emit_data.last       = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = emit ? emit_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      head_r      <= '0;
      held_r      <= '0;
      finished_r  <= 1'b0;
      drained_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      finished_r  <= finished_nxt;
      drained_r   <= drained_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    gap_r      <= gap_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  // length store; read port follows the ring head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_len_mem[store_slot] <= len_r;
    end
    rd_len_r <= slot_len_mem[head_r];
  end

  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared without reset");

  a_drain_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> held_r[head_r])
    else $error("draining a slot that is not held");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (drained_r != SLOT_W'(WINDOW_SLOTS - 1)))
    else $error("drain count beyond window");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r != S_IDLE) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
